### hw/rtl/mrfc_pkg.sv
package mrfc_pkg;

    // Field widths
    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 9;
    localparam int CRC_W   = 16;
    localparam int STAT_W  = 3;

    // CRC-16/MODBUS, reflected
    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

    // Shortest frame: address, function, two crc bytes
    localparam logic [LEN_W-1:0] MIN_FRAME = 9'd4;

    // Input item codes
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_EOF  = 1'b1;

    // Frame status codes; priority is overflow, short, address, then crc
    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_ADDR     = 3'd1,
        ST_CRC      = 3'd2,
        ST_SHORT    = 3'd3,
        ST_OVERFLOW = 3'd4
    } mrfc_status_t;

    // Registered input item
    typedef struct packed {
        logic              valid;
        logic              command;
        logic [BYTE_W-1:0] rx_byte;
        logic              source_port;
    } mrfc_item_t;

    // One frame result
    typedef struct packed {
        mrfc_status_t      status;
        logic [LEN_W-1:0]  length;
        logic              port;
        logic [CRC_W-1:0]  crc;
    } mrfc_result_t;

    // One byte step of the CRC, bit at a time
    function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

### hw/rtl/mrfc_if.sv
// Input item channel
interface mrfc_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] rx_byte;
    logic       source_port;

    modport source (output valid, output command, output rx_byte, output source_port,
                    input ready);
    modport sink   (input valid, input command, input rx_byte, input source_port,
                    output ready);
endinterface

// Frame result channel
interface mrfc_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  frame_status;
    logic [8:0]  frame_length;
    logic        frame_port;
    logic [15:0] computed_crc;

    modport source (output valid, output frame_status, output frame_length,
                    output frame_port, output computed_crc, input ready);
    modport sink   (input valid, input frame_status, input frame_length,
                    input frame_port, input computed_crc, output ready);
endinterface

// Configuration write channel
interface mrfc_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] slave_address;

    modport source (output valid, output slave_address, input ready);
    modport sink   (input valid, input slave_address, output ready);
endinterface

### hw/rtl/mrfc_in_reg.sv
module mrfc_in_reg (
    input  logic              clk,
    input  logic              rst_n,
    mrfc_in_if.sink           rx,
    input  logic              take,
    output mrfc_pkg::mrfc_item_t item
);

    mrfc_pkg::mrfc_item_t item_reg;
    mrfc_pkg::mrfc_item_t item_next;

    // Room when empty or when the held item moves on this cycle
    assign rx.ready = !item_reg.valid || take;
    assign item     = item_reg;

    always_comb
    begin
        item_next = item_reg;
        if (rx.valid && rx.ready)
        begin
            item_next.valid       = 1'b1;
            item_next.command     = rx.command;
            item_next.rx_byte     = rx.rx_byte;
            item_next.source_port = rx.source_port;
        end
        else if (take)
        begin
            item_next.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_reg <= '0;
        end
        else
        begin
            item_reg <= item_next;
        end
    end

endmodule

### hw/rtl/mrfc_frame_core.sv
module mrfc_frame_core #(
    parameter int MAX_FRAME_BYTES = 256
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  mrfc_pkg::mrfc_item_t   item,
    input  logic [7:0]             slave_address,
    output logic                   pending,
    output logic                   fire,
    output mrfc_pkg::mrfc_result_t result
);

    localparam logic [mrfc_pkg::LEN_W-1:0] MAX_COUNT = mrfc_pkg::LEN_W'(MAX_FRAME_BYTES);

    logic [mrfc_pkg::CRC_W-1:0]  crc_reg,   crc_next;
    logic [mrfc_pkg::BYTE_W-1:0] held0_reg, held0_next;
    logic [mrfc_pkg::BYTE_W-1:0] held1_reg, held1_next;
    logic [mrfc_pkg::LEN_W-1:0]  count_reg, count_next;
    logic [mrfc_pkg::BYTE_W-1:0] first_reg, first_next;
    logic                        ovf_reg,   ovf_next;
    logic                        port_reg,  port_next;
    logic [mrfc_pkg::CRC_W-1:0]  rx_crc;

    // A frame is open once a byte or an overrun has been seen
    assign pending = (count_reg != '0) || ovf_reg;
    assign rx_crc  = {held1_reg, held0_reg};

    // Frame status, by priority
    always_comb
    begin
        result.length = count_reg;
        result.port   = port_reg;
        result.crc    = crc_reg;
        if (ovf_reg)
        begin
            result.status = mrfc_pkg::ST_OVERFLOW;
        end
        else if (count_reg < mrfc_pkg::MIN_FRAME)
        begin
            result.status = mrfc_pkg::ST_SHORT;
        end
        else if (first_reg != slave_address)
        begin
            result.status = mrfc_pkg::ST_ADDR;
        end
        else if (rx_crc != crc_reg)
        begin
            result.status = mrfc_pkg::ST_CRC;
        end
        else
        begin
            result.status = mrfc_pkg::ST_OK;
        end
    end

    // Frame state update
    always_comb
    begin
        crc_next   = crc_reg;
        held0_next = held0_reg;
        held1_next = held1_reg;
        count_next = count_reg;
        first_next = first_reg;
        ovf_next   = ovf_reg;
        port_next  = port_reg;
        fire       = 1'b0;
        if (step)
        begin
            if (item.command == mrfc_pkg::CMD_BYTE)
            begin
                port_next = item.source_port;
                if (count_reg == MAX_COUNT)
                begin
                    // buffer full: drop the data, remember the overrun
                    ovf_next = 1'b1;
                end
                else
                begin
                    if (count_reg == '0)
                    begin
                        first_next = item.rx_byte;
                    end
                    // oldest held byte leaves the delay line into the crc
                    if (count_reg >= 9'd2)
                    begin
                        crc_next = mrfc_pkg::crc_feed(crc_reg, held0_reg);
                    end
                    held0_next = held1_reg;
                    held1_next = item.rx_byte;
                    count_next = count_reg + mrfc_pkg::LEN_W'(1);
                end
            end
            else if (pending)
            begin
                fire       = 1'b1;
                crc_next   = mrfc_pkg::CRC_INIT;
                held0_next = '0;
                held1_next = '0;
                count_next = '0;
                first_next = '0;
                ovf_next   = 1'b0;
                port_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg   <= mrfc_pkg::CRC_INIT;
            held0_reg <= '0;
            held1_reg <= '0;
            count_reg <= '0;
            first_reg <= '0;
            ovf_reg   <= 1'b0;
            port_reg  <= 1'b0;
        end
        else
        begin
            crc_reg   <= crc_next;
            held0_reg <= held0_next;
            held1_reg <= held1_next;
            count_reg <= count_next;
            first_reg <= first_next;
            ovf_reg   <= ovf_next;
            port_reg  <= port_next;
        end
    end

endmodule

### hw/rtl/modbus_rtu_frame_checker.sv
// Result path: the end-of-frame item is held in the input register, then, once taken,
// the result is loaded into the result register and shown as valid.
// Throughput: one item per cycle unless stalled; the single CRC byte step per byte sets it.
// A waiting result stalls only an end-of-frame item that closes an open frame.
// Reset (rst_n low, asynchronous): frame state cleared, CRC 0xFFFF,
// slave_address 1, no result pending.
module modbus_rtu_frame_checker #(
    parameter int MAX_FRAME_BYTES = 256
) (
    input  logic      clk,
    input  logic      rst_n,
    mrfc_in_if.sink   rx,
    mrfc_cfg_if.sink  cfg,
    mrfc_out_if.source res
);

    mrfc_pkg::mrfc_item_t   item;
    mrfc_pkg::mrfc_result_t result;
    mrfc_pkg::mrfc_result_t res_reg;
    logic                   res_valid_reg, res_valid_next;
    logic [7:0]             addr_reg;
    logic                   take;
    logic                   pending;
    logic                   fire;

    // Held item moves on unless it would close a frame into a full result slot
    assign take = item.valid &&
                  ((item.command == mrfc_pkg::CMD_BYTE) || !pending ||
                   !res_valid_reg || res.ready);

    mrfc_in_reg u_in_reg (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .take  (take),
        .item  (item)
    );

    mrfc_frame_core #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (take),
        .item          (item),
        .slave_address (addr_reg),
        .pending       (pending),
        .fire          (fire),
        .result        (result)
    );

    // Station address register
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= 8'd1;
        end
        else if (cfg.valid && cfg.ready)
        begin
            addr_reg <= cfg.slave_address;
        end
    end

    // Result register
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (fire)
        begin
            res_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= result;
        end
    end

    assign res.valid        = res_valid_reg;
    assign res.frame_status = res_reg.status;
    assign res.frame_length = res_reg.length;
    assign res.frame_port   = res_reg.port;
    assign res.computed_crc = res_reg.crc;

endmodule

### hw/rtl/mrfc_assert.sv
module mrfc_assert #(
    parameter int MAX_FRAME_BYTES = 256
) (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  out_status,
    input logic [8:0]  out_length,
    input logic [15:0] out_crc
);

    localparam logic [8:0] MAX_COUNT = 9'(MAX_FRAME_BYTES);

    // A stalled result stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_status) && $stable(out_length)
                                    && $stable(out_crc))
        else $error("result changed while stalled");

    // Too short means one to three bytes; no crc byte was folded in unless there were three
    a_short: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_status == mrfc_pkg::ST_SHORT
        |-> out_length != 9'd0 && out_length < mrfc_pkg::MIN_FRAME
            && (out_length == 9'd3 || out_crc == mrfc_pkg::CRC_INIT))
        else $error("bad short frame result");

    // Overrun is only reported with a full buffer
    a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_status == mrfc_pkg::ST_OVERFLOW |-> out_length == MAX_COUNT)
        else $error("overflow without full buffer");

    // Any other status needs a full minimum frame
    a_long: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_status == mrfc_pkg::ST_OK || out_status == mrfc_pkg::ST_ADDR
                      || out_status == mrfc_pkg::ST_CRC)
        |-> out_length >= mrfc_pkg::MIN_FRAME && out_length <= MAX_COUNT)
        else $error("checked frame with bad length");

endmodule

bind modbus_rtu_frame_checker mrfc_assert #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
) u_mrfc_assert (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (res.valid),
    .out_ready  (res.ready),
    .out_status (res.frame_status),
    .out_length (res.frame_length),
    .out_crc    (res.computed_crc)
);

### sim/mrfc_frame_monitor.sv
`timescale 1ns / 1ps

// Shared helpers for the frame checker bench
package mrfc_tb_pkg;

    // CRC-16/MODBUS, one byte, data bits folded into the lsb one at a time
    function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                                 input logic [7:0] data);
        logic [15:0] c;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            if (c[0] ^ data[i]) begin
                c = (c >> 1) ^ mrfc_pkg::CRC_POLY;
            end
            else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// Watches the three channels, predicts each frame result and compares
module mrfc_frame_monitor #(
    parameter int MAX_FRAME_BYTES = 256
) (
    input  logic clk,
    input  logic rst_n,
    mrfc_in_if   rx,
    mrfc_cfg_if  cfg,
    mrfc_out_if  res,
    output int   errors,
    output int   pending,
    output int   checked
);

    // Predicted frame state
    logic [15:0] frame_crc = mrfc_pkg::CRC_INIT;
    logic [7:0]  delay_line [2];
    logic [8:0]  frame_bytes = '0;
    logic [7:0]  addr_byte = '0;
    logic        overrun = 1'b0;
    logic        tail_port = 1'b0;
    logic [7:0]  station_addr = 8'd1;

    mrfc_pkg::mrfc_result_t expected_frames[$];
    int mismatch_count = 0;
    int results_seen = 0;

    assign errors  = mismatch_count;
    assign checked = results_seen;

    task automatic note_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
    endtask

    task automatic clear_frame_state();
        frame_crc     = mrfc_pkg::CRC_INIT;
        delay_line[0] = '0;
        delay_line[1] = '0;
        frame_bytes   = '0;
        addr_byte     = '0;
        overrun       = 1'b0;
        tail_port     = 1'b0;
    endtask

    // One accepted item: byte into the delay line, or close the frame
    task automatic predict_item(input logic cmd, input logic [7:0] data, input logic port);
        mrfc_pkg::mrfc_result_t r;
        logic [15:0]  sent_crc;
        if (cmd == mrfc_pkg::CMD_BYTE) begin
            tail_port = port;
            if (frame_bytes >= MAX_FRAME_BYTES) begin
                overrun = 1'b1;
            end
            else begin
                if (frame_bytes == 0) begin
                    addr_byte = data;
                end
                if (frame_bytes >= 2) begin
                    frame_crc = mrfc_tb_pkg::crc16_update(frame_crc, delay_line[0]);
                end
                delay_line[0] = delay_line[1];
                delay_line[1] = data;
                frame_bytes   = frame_bytes + 9'd1;
            end
        end
        else if (frame_bytes != 0 || overrun) begin
            sent_crc = {delay_line[1], delay_line[0]};
            if (overrun) begin
                r.status = mrfc_pkg::ST_OVERFLOW;
            end
            else if (frame_bytes < mrfc_pkg::MIN_FRAME) begin
                r.status = mrfc_pkg::ST_SHORT;
            end
            else if (addr_byte != station_addr) begin
                r.status = mrfc_pkg::ST_ADDR;
            end
            else if (sent_crc != frame_crc) begin
                r.status = mrfc_pkg::ST_CRC;
            end
            else begin
                r.status = mrfc_pkg::ST_OK;
            end
            r.length = frame_bytes;
            r.port   = tail_port;
            r.crc    = frame_crc;
            expected_frames.push_back(r);
            clear_frame_state();
        end
    endtask

    // Results are compared before the item of the same edge is predicted
    always @(posedge clk or negedge rst_n) begin
        mrfc_pkg::mrfc_result_t want;
        if (!rst_n) begin
            clear_frame_state();
            station_addr = 8'd1;
            expected_frames.delete();
            pending = 0;
        end
        else begin
            if (res.valid && res.ready) begin
                results_seen++;
                if (expected_frames.size() == 0) begin
                    note_mismatch("result with no frame pending", res.frame_status, 0);
                end
                else begin
                    want = expected_frames.pop_front();
                    if (res.frame_status != want.status) begin
                        note_mismatch("frame_status", res.frame_status, want.status);
                    end
                    if (res.frame_length != want.length) begin
                        note_mismatch("frame_length", res.frame_length, want.length);
                    end
                    if (res.frame_port != want.port) begin
                        note_mismatch("frame_port", res.frame_port, want.port);
                    end
                    if (res.computed_crc != want.crc) begin
                        note_mismatch("computed_crc", res.computed_crc, want.crc);
                    end
                end
            end
            if (rx.valid && rx.ready) begin
                predict_item(rx.command, rx.rx_byte, rx.source_port);
            end
            if (cfg.valid && cfg.ready) begin
                station_addr = cfg.slave_address;
            end
            pending = expected_frames.size();
        end
    end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int MAX_FRAME_BYTES = 256;
    localparam int CYCLE_LIMIT     = 300000;
    localparam int PHASE_ITEMS     = 190;

    typedef logic [7:0] byte_q_t[$];

    logic clk = 1'b0;
    logic rst_n;
    logic sink_ready = 1'b0;
    bit   calm = 1'b0;
    int   res_hold = 0;
    int   res_draw;
    int   items_sent = 0;
    int   frames_sent = 0;
    int   addr_settings = 0;
    int   cycles = 0;
    int   errors;
    int   pending;
    int   checked;
    logic [7:0] station = 8'd1;

    mrfc_in_if  rx_ch ();
    mrfc_cfg_if cfg_ch ();
    mrfc_out_if res_ch ();

    assign res_ch.ready = sink_ready;

    modbus_rtu_frame_checker #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) uut (
        .clk  (clk),
        .rst_n(rst_n),
        .rx   (rx_ch),
        .cfg  (cfg_ch),
        .res  (res_ch)
    );

    mrfc_frame_monitor #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) mon (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx_ch),
        .cfg    (cfg_ch),
        .res    (res_ch),
        .errors (errors),
        .pending(pending),
        .checked(checked)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Run-away guard
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("FAILURE");
            $finish;
        end
    end

    // Result sink: random stall after each taken result
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            sink_ready <= 1'b0;
            res_hold   <= 0;
        end
        else if (res_ch.valid && sink_ready) begin
            res_draw = calm ? 0 : $urandom_range(0, 4);
            res_hold   <= res_draw;
            sink_ready <= (res_draw == 0);
        end
        else if (res_hold > 0) begin
            res_hold   <= res_hold - 1;
            sink_ready <= (res_hold == 1);
        end
        else begin
            sink_ready <= 1'b1;
        end
    end

    // Valid stays high across back-to-back items
    task automatic send_item(input logic cmd, input logic [7:0] data, input logic port);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_ch.command     <= cmd;
        rx_ch.rx_byte     <= data;
        rx_ch.source_port <= port;
        rx_ch.valid       <= 1'b1;
        do @(posedge clk); while (!rx_ch.ready);
        items_sent++;
    endtask

    // Bytes on random ports, then the silence event
    task automatic send_frame(input byte_q_t q);
        foreach (q[i]) begin
            send_item(mrfc_pkg::CMD_BYTE, q[i], 1'($urandom_range(0, 1)));
        end
        send_item(mrfc_pkg::CMD_EOF, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        frames_sent++;
    endtask

    // Address, random body, crc low then high; n is at least 4
    function automatic byte_q_t build_frame(input logic [7:0] addr, input int n);
        byte_q_t     q;
        logic [15:0] crc;
        q.push_back(addr);
        for (int i = 1; i <= n - 3; i++) begin
            q.push_back(8'($urandom_range(0, 255)));
        end
        crc = mrfc_pkg::CRC_INIT;
        foreach (q[i]) begin
            crc = mrfc_tb_pkg::crc16_update(crc, q[i]);
        end
        q.push_back(crc[7:0]);
        q.push_back(crc[15:8]);
        return q;
    endfunction

    // Drain outstanding results, then allow for the pipeline
    task automatic wait_idle();
        rx_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_station(input logic [7:0] addr);
        cfg_ch.slave_address <= addr;
        cfg_ch.valid         <= 1'b1;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        station = addr;
        addr_settings++;
    endtask

    // Mostly well-formed frames, some damaged, some noise
    task automatic random_phase(input int quota);
        int      start;
        int      kind;
        byte_q_t q;
        start = items_sent;
        while (items_sent - start < quota) begin
            calm = ($urandom_range(0, 5) == 0);
            kind = $urandom_range(0, 99);
            q.delete();
            if (kind < 45) begin
                q = build_frame(station, $urandom_range(4, 12));
            end
            else if (kind < 60) begin
                // one flipped bit somewhere in the crc bytes
                q = build_frame(station, $urandom_range(4, 12));
                q[q.size() - 1 - $urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
            end
            else if (kind < 70) begin
                q = build_frame(station ^ 8'($urandom_range(1, 255)), $urandom_range(4, 10));
            end
            else if (kind < 80) begin
                q = build_frame(station, 4);
                q = q[0:$urandom_range(0, 2)];
            end
            else begin
                repeat ($urandom_range(0, 20)) q.push_back(8'($urandom_range(0, 255)));
                if (q.size() > 0 && $urandom_range(0, 1)) begin
                    q[0] = station;
                end
            end
            send_frame(q);
        end
    endtask

    initial
    begin
        logic [7:0] phase_addr [5];
        byte_q_t    q;

        rst_n                <= 1'b0;
        rx_ch.valid          <= 1'b0;
        rx_ch.command        <= mrfc_pkg::CMD_BYTE;
        rx_ch.rx_byte        <= '0;
        rx_ch.source_port    <= 1'b0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.slave_address <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: reset address 1 still in force
        send_item(mrfc_pkg::CMD_EOF, 8'hFF, 1'b1);    // empty frame, no result
        send_frame(build_frame(8'h01, 4));            // good minimal frame
        q = '{8'hFF};
        send_frame(q);                                // too short, crc untouched
        q = '{8'h01, 8'h00, 8'hFF};
        send_frame(q);                                // too short, one byte in crc
        q = build_frame(8'h00, 4);
        q[3] ^= 8'h80;
        send_frame(q);                                // address wins over crc error
        q = build_frame(8'h01, 4);
        q[2] ^= 8'h01;
        send_frame(q);                                // crc error

        // Address settings, extremes first
        phase_addr[0] = 8'h00;
        phase_addr[1] = 8'hFF;
        phase_addr[2] = 8'($urandom_range(0, 255));
        phase_addr[3] = 8'h01;
        phase_addr[4] = 8'($urandom_range(0, 255));
        for (int ph = 0; ph < 5; ph++) begin
            wait_idle();
            write_station(phase_addr[ph]);
            if (ph == 2) begin
                // longest legal frame, then one that runs past the buffer
                calm = 1'b0;
                send_frame(build_frame(station, MAX_FRAME_BYTES));
                send_frame(build_frame(station, MAX_FRAME_BYTES + $urandom_range(1, 3)));
                random_phase(PHASE_ITEMS / 2);
            end
            else begin
                random_phase(PHASE_ITEMS);
            end
        end

        wait_idle();
        repeat (4) @(posedge clk);

        $display("covered %0d items in %0d frames, %0d results checked", items_sent,
                 frames_sent, checked);
        $display("station address written %0d times, incl. 0x00, 0xFF and overflow frames",
                 addr_settings);
        if (errors == 0 && pending == 0) begin
            $display("SUCCESS");
        end
        else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/mrfc_pkg.sv
hw/rtl/mrfc_if.sv
hw/rtl/mrfc_in_reg.sv
hw/rtl/mrfc_frame_core.sv
hw/rtl/modbus_rtu_frame_checker.sv
hw/rtl/mrfc_assert.sv
sim/mrfc_frame_monitor.sv
sim/tb_top.sv
